// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by ordered_header_filter_set.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/ohfs_pkg.sv -----
`default_nettype none

package ohfs_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int HDR_W = 16;
    localparam int POS_W = 6;
    localparam int OP_W  = 3;
    localparam int CNT_OUT_W = 7;
    localparam int STS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // result status codes
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_RANGE = 2'd2;

    // control broadcast to every cell
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             del;
        logic [HDR_W-1:0] hdr;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/ohfs_cell.sv -----
`default_nettype none

module ohfs_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                        i_clk,
    input  wire  ohfs_pkg::t_cell_ctl  i_ctl,
    input  wire  [CNT_W-1:0]           i_count,
    input  wire                        i_seen,
    input  wire  [ohfs_pkg::HDR_W-1:0] i_next_entry,
    output logic [ohfs_pkg::HDR_W-1:0] o_entry,
    output logic                       o_match,
    output logic [ohfs_pkg::HDR_W-1:0] o_rd
);

    localparam bit                         POS_OK  = IDX < (1 << ohfs_pkg::POS_W);
    localparam logic [ohfs_pkg::POS_W-1:0] POS_IDX = ohfs_pkg::POS_W'(IDX);
    localparam logic [CNT_W-1:0]           MY_IDX  = CNT_W'(IDX);

    logic [ohfs_pkg::HDR_W-1:0] r_entry;
    logic                       r_match;
    logic [ohfs_pkg::HDR_W-1:0] r_rd;
    logic                       w_live;
    logic                       w_pos_hit;

    assign w_live    = MY_IDX < i_count;
    assign w_pos_hit = POS_OK && (i_ctl.pos == POS_IDX);

    // compare phase: snapshot match and read term
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= w_live && (r_entry == i_ctl.hdr);
            r_rd    <= w_pos_hit ? r_entry : '0;
        end
    end

    // update phase: append at the tail or shift down from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (i_count == MY_IDX)) begin
            r_entry <= i_ctl.hdr;
        end else if (i_ctl.del && i_seen) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire

// ----- rtl/core/ordered_header_filter_set.sv -----
// a request beat is accepted, compared and updated before its result beat;
//   the block takes no new beat until then, as it waits for the compare register
//   stage in every cell followed by the update pass along the cell chain
// reset: synchronous active-low; clears count, control state and result valid,
//   stored headers are not cleared and need no clearing pass
`default_nettype none
`include "assert_macros.svh"

module ordered_header_filter_set #(
    parameter int CAPACITY = ohfs_pkg::CAPACITY_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // request channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [ohfs_pkg::OP_W-1:0]      i_operation,
    input  wire  [ohfs_pkg::HDR_W-1:0]     i_header,
    input  wire  [ohfs_pkg::POS_W-1:0]     i_position,
    // result channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_found,
    output logic [ohfs_pkg::HDR_W-1:0]     o_read_header,
    output logic [ohfs_pkg::CNT_OUT_W-1:0] o_entry_count,
    output logic [ohfs_pkg::STS_W-1:0]     o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + ohfs_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXE  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured request beat
    logic [ohfs_pkg::OP_W-1:0]  r_op;
    logic [ohfs_pkg::HDR_W-1:0] r_hdr;
    logic [ohfs_pkg::POS_W-1:0] r_pos;

    // set state
    logic [CNT_W-1:0] r_count, n_count;

    // result register
    logic                       r_out_valid;
    logic                       r_found, n_found;
    logic [ohfs_pkg::HDR_W-1:0] r_rd, n_rd;
    logic [ohfs_pkg::CNT_OUT_W-1:0] r_out_count;
    logic [ohfs_pkg::STS_W-1:0] r_status, n_status;

    // cell chain wiring
    ohfs_pkg::t_cell_ctl        w_ctl;
    logic [CAPACITY-1:0]        w_match;
    logic [CAPACITY-1:0]        w_seen;
    logic [ohfs_pkg::HDR_W-1:0] w_entry [CAPACITY];
    logic [ohfs_pkg::HDR_W-1:0] w_rd    [CAPACITY];
    logic [ohfs_pkg::HDR_W-1:0] w_rd_or;
    logic                       w_hit;
    logic                       w_accept;
    logic                       w_adv;
    logic                       w_ins;
    logic                       w_del;
    logic                       w_pos_ok;
    logic [CNT_W+ohfs_pkg::CNT_OUT_W-1:0] w_cnt_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // update step fires once the result register is free
    assign w_adv      = (r_state == S_EXE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                if (w_adv) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // matched slot and every slot above it (lowest set bit and up)
    assign w_hit  = |w_match;
    assign w_seen = w_match | (~w_match + CAPACITY'(1));

    // read terms are zero in every cell but the addressed one
    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    assign w_pos_ok = CMP_W'(r_pos) < CMP_W'(r_count);

    // operation decode for the update step
    always_comb begin
        n_count  = r_count;
        n_found  = 1'b0;
        n_rd     = '0;
        n_status = ohfs_pkg::ST_OK;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        unique case (r_op)
            ohfs_pkg::OP_INSERT: begin
                if (w_hit) begin
                    n_found = 1'b1;
                end else if (r_count == CAP_CNT) begin
                    n_status = ohfs_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ohfs_pkg::OP_ERASE: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    w_del   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ohfs_pkg::OP_LOOKUP: begin
                n_found = w_hit;
            end
            ohfs_pkg::OP_READ: begin
                if (w_pos_ok) begin
                    n_rd = w_rd_or;
                end else begin
                    n_status = ohfs_pkg::ST_RANGE;
                end
            end
            ohfs_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase
    end

    // entry count reported modulo 128
    assign w_cnt_ext = {{ohfs_pkg::CNT_OUT_W{1'b0}}, n_count};

    assign w_ctl.cmp = (r_state == S_CMP);
    assign w_ctl.ins = w_adv && w_ins;
    assign w_ctl.del = w_adv && w_del;
    assign w_ctl.hdr = r_hdr;
    assign w_ctl.pos = r_pos;

    // the cell chain: each cell holds one slot in insertion order
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ohfs_pkg::HDR_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        ohfs_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_seen       (w_seen[g]),
            .i_next_entry (w_next),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g]),
            .o_rd         (w_rd[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_count <= n_count;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_hdr <= i_header;
            r_pos <= i_position;
        end
        if (w_adv) begin
            r_found     <= n_found;
            r_rd        <= n_rd;
            r_out_count <= w_cnt_ext[ohfs_pkg::CNT_OUT_W-1:0];
            r_status    <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_read_header = r_rd;
    assign o_entry_count = r_out_count;
    assign o_status      = r_status;

    // count never passes the capacity
    `ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= CAP_CNT)
    // duplicate-free: at most one live cell matches
    `ASSERT_IMPL(a_match_single, i_clk, i_rst_n, r_state == S_EXE, $onehot0(w_match))
    // an accepted beat always moves into the compare step
    `ASSERT_NEXT(a_accept_cmp, i_clk, i_rst_n, w_accept, r_state == S_CMP)
    // clear empties the set
    `ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, w_adv && (r_op == ohfs_pkg::OP_CLEAR),
        r_count == '0)

endmodule

`default_nettype wire

// ----- bench/ordered_header_filter_set_tb.sv -----
`timescale 1ns / 100ps

module ordered_header_filter_set_tb;

    // operation codes the block must ignore
    localparam logic [ohfs_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [ohfs_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [ohfs_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int RANDOM_OPS  = 1500;   // useful operations in the random part
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off, fills the block
    localparam int DRAIN_WAIT  = 12;     // extra wait once no result is pending

    // one result beat, field by field
    typedef struct packed {
        logic                           found;
        logic [ohfs_pkg::HDR_W-1:0]     read_header;
        logic [ohfs_pkg::CNT_OUT_W-1:0] entry_count;
        logic [ohfs_pkg::STS_W-1:0]     status;
    } t_result_beat;

    // operation mixes for the random segments
    typedef enum int { MIX_GROW, MIX_CHURN, MIX_SHRINK } t_op_mix;

    // ordered header set mirror plus the queue of results it predicts
    class t_header_set_book;
        logic [ohfs_pkg::HDR_W-1:0] headers[$];
        t_result_beat               expected[$];
        int                         mismatches;

        function new();
            headers.delete();
            expected.delete();
            mismatches = 0;
        endfunction

        function int stored();
            return headers.size();
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // a header that is currently in the set, caller checks stored() first
        function logic [ohfs_pkg::HDR_W-1:0] pick_present();
            return headers[$urandom_range(0, headers.size() - 1)];
        endfunction

        // apply one accepted request to the mirror, queue its result
        function void note_request(logic [ohfs_pkg::OP_W-1:0] op,
                                   logic [ohfs_pkg::HDR_W-1:0] hdr,
                                   logic [ohfs_pkg::POS_W-1:0] pos);
            t_result_beat want;
            int           slot;
            want = '0;
            slot = -1;
            for (int i = 0; i < headers.size(); i++) begin
                if (slot < 0 && headers[i] == hdr)
                    slot = i;
            end
            case (op)
                ohfs_pkg::OP_INSERT: begin
                    if (slot >= 0)
                        want.found = 1'b1;
                    else if (headers.size() >= ohfs_pkg::CAPACITY_DEF)
                        want.status = ohfs_pkg::ST_FULL;
                    else
                        headers = {headers, hdr};
                end
                ohfs_pkg::OP_ERASE: begin
                    if (slot >= 0) begin
                        want.found = 1'b1;
                        headers.delete(slot);   // later entries move down one place
                    end
                end
                ohfs_pkg::OP_LOOKUP: begin
                    want.found = (slot >= 0);
                end
                ohfs_pkg::OP_READ: begin
                    if (pos < headers.size())
                        want.read_header = headers[pos];
                    else
                        want.status = ohfs_pkg::ST_RANGE;
                end
                ohfs_pkg::OP_CLEAR: begin
                    headers.delete();
                end
                default: ;
            endcase
            want.entry_count = ohfs_pkg::CNT_OUT_W'(headers.size());
            expected = {expected, want};
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // compare one result beat with the oldest prediction
        task check_result(t_result_beat got);
            t_result_beat want;
            if (expected.size() == 0) begin
                report($sformatf("result beat with nothing pending (count %0d)",
                                 got.entry_count));
                return;
            end
            want = expected.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.read_header !== want.read_header)
                report($sformatf("read_header %h, want %h",
                                 got.read_header, want.read_header));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d",
                                 got.entry_count, want.entry_count));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    // clock, reset and block ports; the inputs are known from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [ohfs_pkg::OP_W-1:0]      i_operation = ohfs_pkg::OP_LOOKUP;
    logic [ohfs_pkg::HDR_W-1:0]     i_header = '0;
    logic [ohfs_pkg::POS_W-1:0]     i_position = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic                           o_found;
    logic [ohfs_pkg::HDR_W-1:0]     o_read_header;
    logic [ohfs_pkg::CNT_OUT_W-1:0] o_entry_count;
    logic [ohfs_pkg::STS_W-1:0]     o_status;

    t_header_set_book book;
    bit               calm = 1'b0;      // segment with no idling on either side
    bit               hold_go = 1'b0;   // starts the long hold-off
    bit               hold_off = 1'b0;  // receiver forced to stall

    ordered_header_filter_set uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_header      (i_header),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_read_header (o_read_header),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // idle cycles before a beat, none inside a calm segment
    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    // offer one request beat and wait until it is taken
    // entered just after a rising edge, leaves just after the accepting edge
    task automatic send_request(input logic [ohfs_pkg::OP_W-1:0]  op,
                                input logic [ohfs_pkg::HDR_W-1:0] hdr,
                                input logic [ohfs_pkg::POS_W-1:0] pos);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        // valid either stays high with the new payload or rises here, one write per edge
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_header    <= hdr;
        i_position  <= pos;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        book.note_request(op, hdr, pos);
    endtask

    // short directed walk: empty set, extremes, duplicates, order after erase, clear
    task automatic run_directed();
        send_request(ohfs_pkg::OP_LOOKUP, 16'h1234, 6'd0);    // lookup on empty set
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd0);    // read on empty set
        send_request(ohfs_pkg::OP_ERASE,  16'h1234, 6'd0);    // erase of absent header
        send_request(ohfs_pkg::OP_INSERT, 16'h0000, 6'd0);
        send_request(ohfs_pkg::OP_INSERT, 16'hFFFF, 6'd63);
        send_request(ohfs_pkg::OP_INSERT, 16'hFFFF, 6'd0);    // duplicate insert
        send_request(ohfs_pkg::OP_INSERT, 16'hA5A5, 6'd0);
        send_request(ohfs_pkg::OP_LOOKUP, 16'hFFFF, 6'd0);
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd0);
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd2);    // last valid position
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd3);    // position equal to count
        send_request(ohfs_pkg::OP_READ,   16'hFFFF, 6'd63);   // highest position
        send_request(ohfs_pkg::OP_ERASE,  16'h0000, 6'd0);    // erase at the head
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd0);
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd1);
        send_request(OP_SPARE_A, 16'hFFFF, 6'd63);            // unused codes are ignored
        send_request(OP_SPARE_B, 16'h0000, 6'd0);
        send_request(OP_SPARE_C, 16'h5A5A, 6'd21);
        send_request(ohfs_pkg::OP_ERASE,  16'hA5A5, 6'd0);    // erase at the tail
        send_request(ohfs_pkg::OP_CLEAR,  16'hFFFF, 6'd63);
        send_request(ohfs_pkg::OP_LOOKUP, 16'hFFFF, 6'd0);    // gone after clear
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd0);
        send_request(ohfs_pkg::OP_INSERT, 16'h5A5A, 6'd0);    // usable again after clear
        send_request(ohfs_pkg::OP_READ,   16'h0000, 6'd0);
    endtask

    // draw one request for the given mix
    task automatic pick_request(input  t_op_mix                    mix,
                                output logic [ohfs_pkg::OP_W-1:0]  op,
                                output logic [ohfs_pkg::HDR_W-1:0] hdr,
                                output logic [ohfs_pkg::POS_W-1:0] pos);
        int r;
        int t_ins;
        int t_era;
        int t_look;
        int h;
        case (mix)
            MIX_GROW: begin
                t_ins = 65; t_era = 72; t_look = 84;
            end
            MIX_CHURN: begin
                t_ins = 35; t_era = 65; t_look = 80;
            end
            default: begin
                t_ins = 10; t_era = 65; t_look = 75;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_ins)
            op = ohfs_pkg::OP_INSERT;
        else if (r < t_era)
            op = ohfs_pkg::OP_ERASE;
        else if (r < t_look)
            op = ohfs_pkg::OP_LOOKUP;
        else if (r < 97)
            op = ohfs_pkg::OP_READ;
        else if (r < 98)
            op = ohfs_pkg::OP_CLEAR;
        else
            op = OP_SPARE_A
                 + ohfs_pkg::OP_W'($urandom_range(0, OP_SPARE_C - OP_SPARE_A));

        // headers: present ones for hits, a small pool for re-inserts, any 16-bit code
        h = $urandom_range(0, 9);
        if (h < 4 && book.stored() > 0)
            hdr = book.pick_present();
        else if (h < 7)
            hdr = ohfs_pkg::HDR_W'($urandom_range(0, 95));
        else
            hdr = ohfs_pkg::HDR_W'($urandom());

        // positions: mostly inside the stored range, the rest anywhere
        if ($urandom_range(0, 1) == 1 && book.stored() > 0)
            pos = ohfs_pkg::POS_W'($urandom_range(0, book.stored() - 1));
        else
            pos = ohfs_pkg::POS_W'($urandom_range(0, 63));
    endtask

    // segments of one mix each, so the set fills to capacity and drains again
    task automatic run_random();
        int                         useful;
        int                         seg_len;
        t_op_mix                    mix;
        logic [ohfs_pkg::OP_W-1:0]  op;
        logic [ohfs_pkg::HDR_W-1:0] hdr;
        logic [ohfs_pkg::POS_W-1:0] pos;
        useful = 0;
        while (useful < RANDOM_OPS) begin
            seg_len = $urandom_range(40, 160);
            mix     = t_op_mix'($urandom_range(0, 2));
            calm    = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len; k++) begin
                pick_request(mix, op, hdr, pos);
                send_request(op, hdr, pos);
                if (op <= ohfs_pkg::OP_CLEAR)
                    useful++;
            end
        end
        calm = 1'b0;
    endtask

    // result side: check at the rising edge, move ready at the falling edge
    initial begin : result_side
        int           stall;
        t_result_beat got;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.found       = o_found;
                got.read_header = o_read_header;
                got.entry_count = o_entry_count;
                got.status      = o_status;
                book.check_result(got);
                stall = draw_gap();
            end
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !hold_off;
            end
        end
    end

    // long receiver hold-off while requests keep coming, so the block backs up
    initial begin : hold_off_window
        wait (hold_go);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : stimulus
        book = new();
        // reset held low, then released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        hold_go = 1'b1;
        run_random();

        // last beat taken, drop valid and let the results drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("ordered_header_filter_set: match");
        end else begin
            $display("ordered_header_filter_set: mismatch");
        end
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("ordered_header_filter_set: mismatch");
        $finish;
    end

endmodule

// ----- ordered_header_filter_set.f -----
+incdir+rtl/core
rtl/core/ohfs_pkg.sv
rtl/core/ohfs_cell.sv
rtl/core/ordered_header_filter_set.sv
bench/ordered_header_filter_set_tb.sv
